// File: rtl/core/ipc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, character codes and operator helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package ipc_pkg;

  // Default operator stack depth
  localparam int unsigned STACK_DEPTH_DEF = 32;

  // Character codes
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_Z  = 8'h7A;  // 'z'

  // Command codes
  localparam logic CMD_CHAR  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Operator codes as held on the stack
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_OPEN  = 3'd1,
    OP_PLUS  = 3'd2,
    OP_MINUS = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5,
    OP_POW   = 3'd6
  } op_code_e;

  // Stack commands from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

  // Stack status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  // Map a character to its operator code
  function automatic op_code_e code_of(input logic [7:0] sym);
    op_code_e code;
    case (sym)
      CH_OPEN:  code = OP_OPEN;
      CH_PLUS:  code = OP_PLUS;
      CH_MINUS: code = OP_MINUS;
      CH_MUL:   code = OP_MUL;
      CH_DIV:   code = OP_DIV;
      CH_POW:   code = OP_POW;
      default:  code = OP_NONE;
    endcase
    return code;
  endfunction

  // Operator precedence, '(' lowest
  function automatic logic [1:0] op_prec(input op_code_e code);
    logic [1:0] prec;
    case (code)
      OP_PLUS, OP_MINUS: prec = 2'd1;
      OP_MUL, OP_DIV:    prec = 2'd2;
      OP_POW:            prec = 2'd3;
      default:           prec = 2'd0;
    endcase
    return prec;
  endfunction

  // Operator code back to its character
  function automatic logic [7:0] op_ascii(input op_code_e code);
    logic [7:0] ch;
    case (code)
      OP_OPEN:  ch = CH_OPEN;
      OP_PLUS:  ch = CH_PLUS;
      OP_MINUS: ch = CH_MINUS;
      OP_MUL:   ch = CH_MUL;
      OP_DIV:   ch = CH_DIV;
      OP_POW:   ch = CH_POW;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  // ASCII letter test
  function automatic logic is_letter(input logic [7:0] sym);
    return ((sym >= CH_LO_A) && (sym <= CH_LO_Z)) ||
           ((sym >= CH_UP_A) && (sym <= CH_UP_Z));
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/infix_to_postfix_converter_top.sv
`default_nettype none
// A letter is latched, then held in the hold-back slot, then loaded into the
// output register. An operator, parenthesis or flush stalls the input while
// the sequencer pops the stack, one entry per step. No new item is taken until
// the last one is done; an ignored byte causes no stall; an output stall holds
// the sequencer. Reset clears the fill count, error flags and sequencer; no
// clearing pass.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: takes infix characters and streams out postfix.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
  parameter int unsigned STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire        command_i,
  input  wire  [7:0] symbol_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] out_symbol_o,
  output logic       end_marker_o,
  output logic       last_of_run_o,
  output logic [1:0] error_flags_o
);
  import ipc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    KIND_FLUSH,
    KIND_LETTER,
    KIND_CLOSE,
    KIND_OPEN,
    KIND_OPER
  } kind_e;

  state_e     state_q, state_d;
  kind_e      kind_q, kind_d;
  logic       kind_ok;
  op_code_e   code_q;
  logic [7:0] sym_q;
  logic [1:0] err_q, err_d;

  // Hold-back slot: one emitted item waits here until its last flag is known
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_sym_q;
  logic       pend_end_q;
  logic [1:0] pend_err_q;

  logic       emit;
  logic [7:0] emit_sym;
  logic       emit_end;
  logic [1:0] emit_err;

  logic       out_valid_q;
  logic [7:0] out_sym_q;
  logic       out_end_q;
  logic       out_last_q;
  logic [1:0] out_err_q;
  logic       out_free;
  logic       out_load;
  logic       out_last;

  logic       accept;
  logic       step_go;

  stk_ctrl_t  stk_ctrl;
  stk_stat_t  stk_stat;
  op_code_e   stk_top;

  ipc_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (stk_ctrl),
    .data_i (code_q),
    .top_o  (stk_top),
    .stat_o (stk_stat)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_go    = !pend_valid_q || out_free;

  // Classify the incoming item
  always_comb begin
    kind_d  = KIND_FLUSH;
    kind_ok = 1'b1;
    if (command_i == CMD_FLUSH) begin
      kind_d = KIND_FLUSH;
    end else if (is_letter(symbol_i)) begin
      kind_d = KIND_LETTER;
    end else if (symbol_i == CH_CLOSE) begin
      kind_d = KIND_CLOSE;
    end else if (code_of(symbol_i) == OP_OPEN) begin
      kind_d = KIND_OPEN;
    end else if (code_of(symbol_i) != OP_NONE) begin
      kind_d = KIND_OPER;
    end else begin
      kind_ok = 1'b0;
    end
  end

  // Sequencer: one stack step per cycle, unless the output holds it back
  always_comb begin
    state_d      = state_q;
    err_d        = err_q;
    stk_ctrl     = '0;
    emit         = 1'b0;
    emit_sym     = '0;
    emit_end     = 1'b0;
    emit_err     = '0;
    out_load     = 1'b0;
    out_last     = 1'b0;
    pend_valid_d = pend_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && kind_ok) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_go) begin
          case (kind_q)
            KIND_FLUSH: begin
              if (!stk_stat.empty) begin
                stk_ctrl.pop = 1'b1;
                if (stk_top == OP_OPEN || stk_top == OP_NONE) begin
                  err_d[1] = 1'b1;
                end else begin
                  emit     = 1'b1;
                  emit_sym = op_ascii(stk_top);
                end
              end else begin
                emit           = 1'b1;
                emit_end       = 1'b1;
                emit_err       = err_q;
                stk_ctrl.clear = 1'b1;
                err_d          = '0;
                state_d        = ST_FIN;
              end
            end
            KIND_LETTER: begin
              emit     = 1'b1;
              emit_sym = sym_q;
              state_d  = ST_FIN;
            end
            KIND_CLOSE: begin
              if (stk_stat.empty) begin
                err_d[1] = 1'b1;
                state_d  = ST_FIN;
              end else begin
                stk_ctrl.pop = 1'b1;
                if (stk_top == OP_OPEN) begin
                  state_d = ST_FIN;
                end else if (stk_top != OP_NONE) begin
                  emit     = 1'b1;
                  emit_sym = op_ascii(stk_top);
                end
              end
            end
            KIND_OPEN: begin
              stk_ctrl.push = 1'b1;
              if (stk_stat.full) begin
                err_d[0] = 1'b1;
              end
              state_d = ST_FIN;
            end
            KIND_OPER: begin
              if (!stk_stat.empty && stk_top != OP_OPEN &&
                  op_prec(stk_top) >= op_prec(code_q)) begin
                stk_ctrl.pop = 1'b1;
                emit         = 1'b1;
                emit_sym     = op_ascii(stk_top);
              end else begin
                stk_ctrl.push = 1'b1;
                if (stk_stat.full) begin
                  err_d[0] = 1'b1;
                end
                state_d = ST_FIN;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
          // Move the held item out once a newer one arrives
          if (emit) begin
            out_load     = pend_valid_q;
            pend_valid_d = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last     = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      err_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      err_q        <= err_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      code_q <= code_of(symbol_i);
      sym_q  <= symbol_i;
    end
  end

  // Hold-back slot payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_sym_q <= emit_sym;
      pend_end_q <= emit_end;
      pend_err_q <= emit_err;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sym_q  <= pend_sym_q;
      out_end_q  <= pend_end_q;
      out_err_q  <= pend_err_q;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_symbol_o  = out_sym_q;
  assign end_marker_o  = out_end_q;
  assign last_of_run_o = out_last_q;
  assign error_flags_o = out_err_q;

endmodule
`default_nettype wire

// File: rtl/core/ipc_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipc_stack
// Operator stack: a memory with a fill count and a registered top entry.
// The read address follows the next count, so the top is valid in every cycle that the stack is not empty.
// ----------------------------------------------------------------------------
module ipc_stack #(
  parameter int unsigned STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ipc_pkg::stk_ctrl_t  ctrl_i,
  input  ipc_pkg::op_code_e   data_i,
  output ipc_pkg::op_code_e   top_o,
  output ipc_pkg::stk_stat_t  stat_o
);
  import ipc_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  op_code_e           mem_q [STACK_DEPTH];
  op_code_e           rd_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic [CntW-1:0]    count_m1;
  logic [AddrW-1:0]   wr_addr;
  logic [AddrW-1:0]   rd_addr;
  logic               full;
  logic               empty;
  logic               wr_en;

  assign full  = (count_q == CntW'(STACK_DEPTH));
  assign empty = (count_q == '0);
  assign wr_en = ctrl_i.push && !full;

  // Next fill count
  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop && !empty) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Address the entry that is top after this cycle
  assign count_m1 = count_d - CntW'(1);
  assign rd_addr  = (count_d == '0) ? '0 : count_m1[AddrW-1:0];
  assign wr_addr  = count_q[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Write on push, read the next top with bypass of a same-cycle write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= data_i;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_q <= data_i;
    end else begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign top_o        = rd_q;
  assign stat_o.empty = empty;
  assign stat_o.full  = full;

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the infix to postfix converter: a directed table of characters and
// flushes with typed or predicted results, then random expressions, noise and
// deep nesting against an in-bench shunting-yard predictor under varied idling.
// ----------------------------------------------------------------------------
module tb;
  import ipc_pkg::*;

  localparam int unsigned DEPTH       = STACK_DEPTH_DEF;
  localparam int          DRAIN       = DEPTH + 8;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          PHASE_ITEMS = 44;
  localparam int          NDIR        = 25;
  localparam int          REPORT_MAX  = 10;

  // Sticky error flags as carried on the end item
  localparam logic [1:0] ERRS_NONE  = 2'b00;
  localparam logic [1:0] ERRS_OVF   = 2'b01;
  localparam logic [1:0] ERRS_PAREN = 2'b10;

  typedef struct packed {
    logic [7:0] sym;
    logic       end_mk;
    logic       last;
    logic [1:0] err;
  } postfix_t;

  // How a table row is checked
  typedef enum logic [1:0] {
    ROW_PRED = 2'd0,  // expectation from the predictor
    ROW_NONE = 2'd1,  // no result at all
    ROW_ONE  = 2'd2   // one result, typed in the row
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       cmd;
    logic [7:0] ch;
    logic [7:0] t_sym;
    logic       t_end;
    logic [1:0] t_err;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       command_i;
  logic [7:0] symbol_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_symbol_o;
  logic       end_marker_o;
  logic       last_of_run_o;
  logic [1:0] error_flags_o;

  // Predictor state
  op_code_e    op_stack [DEPTH];
  int unsigned op_depth;
  logic [1:0]  err_sticky;

  postfix_t postfix_q [$];  // results still owed by the block
  postfix_t run_q [$];      // results of the item just predicted
  dir_row_t dir_tab [NDIR];

  int gap_pct;
  int stall_pct;
  int mismatch_cnt;
  int phase_items;
  int idle_cycles;

  infix_to_postfix_converter_top #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .symbol_i     (symbol_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_symbol_o (out_symbol_o),
    .end_marker_o (end_marker_o),
    .last_of_run_o(last_of_run_o),
    .error_flags_o(error_flags_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
  endfunction

  function automatic op_code_e to_op(input logic [7:0] ch);
    case (ch)
      CH_OPEN:  return OP_OPEN;
      CH_PLUS:  return OP_PLUS;
      CH_MINUS: return OP_MINUS;
      CH_MUL:   return OP_MUL;
      CH_DIV:   return OP_DIV;
      CH_POW:   return OP_POW;
      default:  return OP_NONE;
    endcase
  endfunction

  function automatic logic [7:0] to_char(input op_code_e op);
    case (op)
      OP_PLUS:  return CH_PLUS;
      OP_MINUS: return CH_MINUS;
      OP_MUL:   return CH_MUL;
      OP_DIV:   return CH_DIV;
      OP_POW:   return CH_POW;
      default:  return 8'h00;
    endcase
  endfunction

  function automatic int rank_of(input op_code_e op);
    case (op)
      OP_POW:         return 3;
      OP_MUL, OP_DIV: return 2;
      OP_PLUS, OP_MINUS: return 1;
      default:        return 0;
    endcase
  endfunction

  function automatic void emit_sym(input logic [7:0] s, input logic e, input logic [1:0] f);
    postfix_t r;
    r.sym    = s;
    r.end_mk = e;
    r.last   = 1'b0;
    r.err    = f;
    run_q.push_back(r);
  endfunction

  // Advance the converter state by one item and collect what it emits
  function automatic void shunt_step(input logic cmd, input logic [7:0] ch);
    op_code_e code;
    op_code_e top;
    logic     stop;
    run_q.delete();
    stop = 1'b0;
    if (cmd == CMD_FLUSH) begin
      // unwind the stack, dropping open parentheses
      while (op_depth > 0) begin
        op_depth--;
        top = op_stack[op_depth];
        if (top == OP_OPEN) err_sticky |= ERRS_PAREN;
        else emit_sym(to_char(top), 1'b0, ERRS_NONE);
      end
      emit_sym(8'h00, 1'b1, err_sticky);
      err_sticky = ERRS_NONE;
    end else if (is_alpha(ch)) begin
      emit_sym(ch, 1'b0, ERRS_NONE);
    end else if (ch == CH_CLOSE) begin
      // pop down to the matching open
      while (op_depth > 0 && !stop) begin
        op_depth--;
        top = op_stack[op_depth];
        if (top == OP_OPEN) stop = 1'b1;
        else emit_sym(to_char(top), 1'b0, ERRS_NONE);
      end
      if (!stop) err_sticky |= ERRS_PAREN;
    end else begin
      code = to_op(ch);
      if (code != OP_NONE) begin
        if (code != OP_OPEN) begin
          // pop operators that bind at least as tightly
          while (op_depth > 0 && !stop) begin
            top = op_stack[op_depth - 1];
            if (top == OP_OPEN || rank_of(top) < rank_of(code)) begin
              stop = 1'b1;
            end else begin
              op_depth--;
              emit_sym(to_char(top), 1'b0, ERRS_NONE);
            end
          end
        end
        if (op_depth >= DEPTH) begin
          err_sticky |= ERRS_OVF;
        end else begin
          op_stack[op_depth] = code;
          op_depth++;
        end
      end
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void note_fail(input string what, input postfix_t want,
                                    input postfix_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%0t %s: expected sym=%h end=%b last=%b err=%b, got sym=%h end=%b last=%b err=%b",
               $time, what, want.sym, want.end_mk, want.last, want.err,
               got.sym, got.end_mk, got.last, got.err);
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    postfix_t got;
    postfix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_symbol_o, end_marker_o, last_of_run_o, error_flags_o};
      if (postfix_q.size() == 0) begin
        note_fail("unexpected result", '0, got);
      end else begin
        want = postfix_q.pop_front();
        if (got.sym !== want.sym || got.end_mk !== want.end_mk ||
            got.last !== want.last || got.err !== want.err)
          note_fail("result mismatch", want, got);
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [7:0] ch,
                           input row_kind_e kind, input postfix_t typed);
    postfix_t hit;
    // hold off the item for a random gap
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    symbol_i   <= ch;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shunt_step(cmd, ch);
    case (kind)
      ROW_PRED: foreach (run_q[i]) postfix_q.push_back(run_q[i]);
      ROW_ONE: begin
        hit      = typed;
        hit.last = 1'b1;
        postfix_q.push_back(hit);
      end
      default: ;
    endcase
  endtask

  task automatic put_item(input logic cmd, input logic [7:0] ch);
    if (cmd == CMD_FLUSH || is_alpha(ch) || to_op(ch) != OP_NONE || ch == CH_CLOSE)
      phase_items++;
    send_item(cmd, ch, ROW_PRED, '0);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) return CH_UP_A + 8'($urandom_range(25));
    return CH_LO_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // Well-formed expression with random shape, then flush
  task automatic gen_expr();
    int   opens;
    int   terms;
    int   max_terms;
    logic want_operand;
    logic done;
    opens        = 0;
    terms        = 0;
    max_terms    = $urandom_range(1, 8);
    want_operand = 1'b1;
    done         = 1'b0;
    while (!done) begin
      if (want_operand) begin
        if (opens < 4 && terms < max_terms && $urandom_range(99) < 25) begin
          put_item(CMD_CHAR, CH_OPEN);
          opens++;
        end else begin
          put_item(CMD_CHAR, rand_letter());
          terms++;
          want_operand = 1'b0;
        end
      end else if (opens > 0 && $urandom_range(99) < 35) begin
        put_item(CMD_CHAR, CH_CLOSE);
        opens--;
      end else if (terms < max_terms) begin
        put_item(CMD_CHAR, rand_op());
        want_operand = 1'b1;
      end else if (opens > 0) begin
        put_item(CMD_CHAR, CH_CLOSE);
        opens--;
      end else begin
        done = 1'b1;
      end
    end
    put_item(CMD_FLUSH, 8'($urandom_range(255)));
  endtask

  // Random mix of expression characters, mostly flushed
  task automatic gen_broken();
    int n;
    n = $urandom_range(3, 12);
    repeat (n) begin
      case ($urandom_range(3))
        0:       put_item(CMD_CHAR, rand_letter());
        1:       put_item(CMD_CHAR, rand_op());
        2:       put_item(CMD_CHAR, CH_OPEN);
        default: put_item(CMD_CHAR, CH_CLOSE);
      endcase
    end
    if ($urandom_range(99) < 80) put_item(CMD_FLUSH, 8'($urandom_range(255)));
  endtask

  // Any byte, any command
  task automatic gen_noise();
    int n;
    n = $urandom_range(2, 6);
    repeat (n)
      put_item(($urandom_range(99) < 10) ? CMD_FLUSH : CMD_CHAR, 8'($urandom_range(255)));
  endtask

  // Mostly opens, more items than the stack depth, then flush
  task automatic gen_deep();
    int n;
    int pick;
    n = $urandom_range(DEPTH + 1, DEPTH + 8);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 70) put_item(CMD_CHAR, CH_OPEN);
      else if (pick < 90) put_item(CMD_CHAR, rand_op());
      else put_item(CMD_CHAR, rand_letter());
    end
    put_item(CMD_FLUSH, 8'h00);
  endtask

  // Drop valid and let every owed result come back
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (postfix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  initial begin
    int pick;
    in_valid_i   = 1'b0;
    command_i    = CMD_CHAR;
    symbol_i     = 8'h00;
    rst_ni       = 1'b0;
    gap_pct      = 0;
    stall_pct    = 0;
    mismatch_cnt = 0;
    phase_items  = 0;
    idle_cycles  = 0;
    op_depth     = 0;
    err_sticky   = ERRS_NONE;

    dir_tab = '{
      '{ROW_ONE,  CMD_FLUSH, 8'hFF,    8'h00,    1'b1, ERRS_NONE},   // flush after reset
      '{ROW_ONE,  CMD_CHAR,  CH_UP_A,  CH_UP_A,  1'b0, ERRS_NONE},
      '{ROW_ONE,  CMD_CHAR,  CH_UP_Z,  CH_UP_Z,  1'b0, ERRS_NONE},
      '{ROW_ONE,  CMD_CHAR,  CH_LO_A,  CH_LO_A,  1'b0, ERRS_NONE},
      '{ROW_ONE,  CMD_CHAR,  CH_LO_Z,  CH_LO_Z,  1'b0, ERRS_NONE},
      '{ROW_NONE, CMD_CHAR,  8'h00,    8'h00,    1'b0, ERRS_NONE},   // ignored bytes
      '{ROW_NONE, CMD_CHAR,  8'hFF,    8'h00,    1'b0, ERRS_NONE},
      '{ROW_NONE, CMD_CHAR,  8'h40,    8'h00,    1'b0, ERRS_NONE},   // just below 'A'
      '{ROW_NONE, CMD_CHAR,  CH_CLOSE, 8'h00,    1'b0, ERRS_NONE},   // close without open
      '{ROW_ONE,  CMD_FLUSH, 8'h00,    8'h00,    1'b1, ERRS_PAREN},
      '{ROW_NONE, CMD_CHAR,  CH_OPEN,  8'h00,    1'b0, ERRS_NONE},
      '{ROW_ONE,  CMD_CHAR,  8'h78,    8'h78,    1'b0, ERRS_NONE},   // 'x'
      '{ROW_NONE, CMD_CHAR,  CH_PLUS,  8'h00,    1'b0, ERRS_NONE},
      '{ROW_ONE,  CMD_CHAR,  8'h79,    8'h79,    1'b0, ERRS_NONE},   // 'y'
      '{ROW_NONE, CMD_CHAR,  CH_MUL,   8'h00,    1'b0, ERRS_NONE},
      '{ROW_NONE, CMD_CHAR,  CH_POW,   8'h00,    1'b0, ERRS_NONE},
      '{ROW_PRED, CMD_CHAR,  CH_POW,   8'h00,    1'b0, ERRS_NONE},   // equal power pops
      '{ROW_PRED, CMD_CHAR,  CH_MINUS, 8'h00,    1'b0, ERRS_NONE},
      '{ROW_PRED, CMD_CHAR,  CH_DIV,   8'h00,    1'b0, ERRS_NONE},
      '{ROW_PRED, CMD_CHAR,  CH_CLOSE, 8'h00,    1'b0, ERRS_NONE},
      '{ROW_PRED, CMD_CHAR,  8'h62,    8'h00,    1'b0, ERRS_NONE},   // 'b'
      '{ROW_PRED, CMD_CHAR,  CH_DIV,   8'h00,    1'b0, ERRS_NONE},
      '{ROW_PRED, CMD_FLUSH, 8'h00,    8'h00,    1'b0, ERRS_NONE},
      '{ROW_NONE, CMD_CHAR,  CH_OPEN,  8'h00,    1'b0, ERRS_NONE},
      '{ROW_ONE,  CMD_FLUSH, 8'h00,    8'h00,    1'b1, ERRS_PAREN}   // leftover open
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].ch, dir_tab[i].kind,
                '{dir_tab[i].t_sym, dir_tab[i].t_end, 1'b1, dir_tab[i].t_err});

    // Random part in four idling phases, draining between them
    for (int p = 0; p < 4; p++) begin
      quiesce();
      case (p)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 57; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 7;  stall_pct = 7;  end
      endcase
      phase_items = 0;
      if (p == 0) gen_deep();
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 62) gen_expr();
        else if (pick < 80) gen_broken();
        else if (pick < 97) gen_noise();
        else gen_deep();
      end
    end

    quiesce();
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ipc_pkg.sv
rtl/core/ipc_stack.sv
rtl/core/infix_to_postfix_converter_top.sv
test/tb.sv
